>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, off while reset is held.
`define MTCP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mtcp check failed");
// Same, with reset taken into account by the property itself.
`define MTCP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("mtcp check failed");
`endif

>>> hdl/mtcp_pkg.sv
// Types, codes and constants of the MIDI track chunk parser.
package mtcp_pkg;

  localparam int TICK_BITS_DEF = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int OUT_DATA_BITS = 112;

  localparam logic [3:0] K_TEMPO    = 4'd7;
  localparam logic [3:0] K_SYSSTART = 4'd8;
  localparam logic [3:0] K_SYSBYTE  = 4'd9;
  localparam logic [3:0] K_EOT      = 4'd10;
  localparam logic [3:0] K_ERROR    = 4'd11;

  localparam logic [7:0] ST_SYSEX   = 8'hf0;
  localparam logic [7:0] ST_ESCAPE  = 8'hf7;
  localparam logic [7:0] ST_META    = 8'hff;
  localparam logic [7:0] META_EOT   = 8'h2f;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_PORT  = 8'h21;

  typedef enum logic [3:0] {
    PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_SYSLEN,
    PH_SYSDATA, PH_METATYPE, PH_METALEN, PH_TEMPO, PH_SKIP
  } phase_t;

  // Everything one input byte produces: an optional main result, an optional
  // F0 sysex byte and an optional truncation error.
  typedef struct packed {
    logic        has_main;
    logic        has_f0;
    logic        has_err;
    logic [3:0]  kind;
    logic [31:0] tick;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [23:0] tempo_value;
    logic [28:0] syx_len;
    logic [7:0]  sysex_data;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

>>> hdl/mtcp_front.sv
// Front end: parses track bytes and builds one result bundle per byte.
module mtcp_front #(
  parameter int TICK_BITS = mtcp_pkg::TICK_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic             cfg_data,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic             in_end,
  input  mtcp_pkg::qstat_t qstat,
  output logic             in_ready,
  output logic             push,
  output mtcp_pkg::bundle_t push_data
);
  import mtcp_pkg::*;

  logic                 smpte_r;
  phase_t               phase_r, phase_nxt;
  logic [7:0]           rs_r, rs_nxt, cmd_r, cmd_nxt, mtype_r, mtype_nxt;
  logic [TICK_BITS-1:0] tick_r, tick_nxt;
  logic [27:0]          vacc_r, vacc_nxt, brem_r, brem_nxt;
  logic [1:0]           vseen_r, vseen_nxt;
  logic [6:0]           held_r, held_nxt;
  logic [23:0]          tacc_r, tacc_nxt;
  logic                 done_r, done_nxt;
  bundle_t              bun;

  logic        accept;
  logic [27:0] vl_acc;
  logic [1:0]  vl_seen;
  logic        vl_done, vl_err;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (bun.has_main || bun.has_f0 || bun.has_err);
  assign push_data = bun;

  // varlen step
  always_comb begin
    vl_acc = {vacc_r[20:0], in_byte[6:0]};
    if (vseen_r == 2'd3) begin
      vl_seen = 2'd0;
      vl_err  = in_byte[7];
      vl_done = !in_byte[7];
    end else begin
      vl_err = 1'b0;
      if (in_byte[7]) begin
        vl_seen = vseen_r + 2'd1;
        vl_done = 1'b0;
      end else begin
        vl_seen = 2'd0;
        vl_done = 1'b1;
      end
    end
  end

  always_comb begin
    logic [3:0]  hi;
    logic        dat;
    logic [27:0] len;
    hi = 4'd0;
    dat = 1'b0;
    len = vl_acc;
    phase_nxt = phase_r; rs_nxt = rs_r; cmd_nxt = cmd_r; mtype_nxt = mtype_r;
    tick_nxt = tick_r; vacc_nxt = vacc_r; brem_nxt = brem_r; vseen_nxt = vseen_r;
    held_nxt = held_r; tacc_nxt = tacc_r; done_nxt = done_r;
    bun = '0;
    if (!done_r) begin
      unique case (phase_r)
        PH_DELTA: begin
          vacc_nxt = vl_acc;
          vseen_nxt = vl_seen;
          if (vl_err) begin
            bun.has_main = 1'b1; bun.kind = K_ERROR; done_nxt = 1'b1;
          end else if (vl_done) begin
            tick_nxt = tick_r + TICK_BITS'(vl_acc);
            vacc_nxt = '0;
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (in_byte[7]) begin
            cmd_nxt = in_byte;
            if (in_byte < ST_SYSEX) rs_nxt = in_byte;
          end else begin
            cmd_nxt = rs_r;
            dat = 1'b1;
          end
          hi = cmd_nxt[7:4];
          if (dat && rs_r == 8'd0) begin
            bun.has_main = 1'b1; bun.kind = K_ERROR; done_nxt = 1'b1;
          end else if (hi == 4'h8 || hi == 4'h9 || hi == 4'ha || hi == 4'hb ||
                       hi == 4'he) begin
            if (dat) begin
              held_nxt = in_byte[6:0]; phase_nxt = PH_DATA2;
            end else phase_nxt = PH_DATA1;
          end else if (hi == 4'hc || hi == 4'hd) begin
            if (dat) begin
              bun.has_main = 1'b1; bun.kind = hi - 4'd8;
              bun.channel = cmd_nxt[3:0]; bun.first_data = in_byte[6:0];
              phase_nxt = PH_DELTA;
            end else phase_nxt = PH_DATA1;
          end else if (cmd_nxt == ST_SYSEX || cmd_nxt == ST_ESCAPE) begin
            vacc_nxt = '0; phase_nxt = PH_SYSLEN;
          end else if (cmd_nxt == ST_META) begin
            phase_nxt = PH_METATYPE;
          end else begin
            bun.has_main = 1'b1; bun.kind = K_ERROR; done_nxt = 1'b1;
          end
        end
        PH_DATA1: begin
          hi = cmd_r[7:4];
          if (hi == 4'h8 || hi == 4'h9 || hi == 4'ha || hi == 4'hb || hi == 4'he) begin
            held_nxt = in_byte[6:0]; phase_nxt = PH_DATA2;
          end else begin
            bun.has_main = 1'b1; bun.kind = hi - 4'd8;
            bun.channel = cmd_r[3:0]; bun.first_data = in_byte[6:0];
            phase_nxt = PH_DELTA;
          end
        end
        PH_DATA2: begin
          bun.has_main = 1'b1; bun.kind = cmd_r[7:4] - 4'd8;
          bun.channel = cmd_r[3:0]; bun.first_data = held_r;
          bun.second_data = in_byte[6:0];
          phase_nxt = PH_DELTA;
        end
        PH_SYSLEN: begin
          vacc_nxt = vl_acc;
          vseen_nxt = vl_seen;
          if (vl_err) begin
            bun.has_main = 1'b1; bun.kind = K_ERROR; done_nxt = 1'b1;
          end else if (vl_done) begin
            vacc_nxt = '0;
            bun.has_main = 1'b1; bun.kind = K_SYSSTART;
            bun.syx_len = {1'b0, len} + {28'd0, cmd_r == ST_SYSEX};
            bun.has_f0 = (cmd_r == ST_SYSEX);
            brem_nxt = len;
            phase_nxt = (len != 28'd0) ? PH_SYSDATA : PH_DELTA;
          end
        end
        PH_SYSDATA: begin
          bun.has_main = 1'b1; bun.kind = K_SYSBYTE; bun.sysex_data = in_byte;
          brem_nxt = brem_r - 28'd1;
          if (brem_nxt == 28'd0) phase_nxt = PH_DELTA;
        end
        PH_METATYPE: begin
          mtype_nxt = in_byte; vacc_nxt = '0; phase_nxt = PH_METALEN;
        end
        PH_METALEN: begin
          vacc_nxt = vl_acc;
          vseen_nxt = vl_seen;
          if (vl_err) begin
            bun.has_main = 1'b1; bun.kind = K_ERROR; done_nxt = 1'b1;
          end else if (vl_done) begin
            vacc_nxt = '0;
            if (mtype_r == META_EOT) begin
              bun.has_main = 1'b1; bun.kind = K_EOT; done_nxt = 1'b1;
            end else if (mtype_r == META_PORT) begin
              if (len == 28'd0) begin
                bun.has_main = 1'b1; bun.kind = K_ERROR; done_nxt = 1'b1;
              end else begin
                brem_nxt = len; phase_nxt = PH_SKIP;
              end
            end else if (mtype_r == META_TEMPO) begin
              if (len < 28'd3) begin
                bun.has_main = 1'b1; bun.kind = K_ERROR; done_nxt = 1'b1;
              end else if (smpte_r) begin
                brem_nxt = len; phase_nxt = PH_SKIP;
              end else begin
                brem_nxt = len - 28'd3; tacc_nxt = '0; vseen_nxt = 2'd0;
                phase_nxt = PH_TEMPO;
              end
            end else begin
              brem_nxt = len;
              phase_nxt = (len != 28'd0) ? PH_SKIP : PH_DELTA;
            end
          end
        end
        PH_TEMPO: begin
          tacc_nxt = {tacc_r[15:0], in_byte};
          vseen_nxt = vseen_r + 2'd1;
          if (vseen_r == 2'd2) begin
            vseen_nxt = 2'd0;
            bun.has_main = 1'b1; bun.kind = K_TEMPO; bun.tempo_value = tacc_nxt;
            phase_nxt = (brem_r != 28'd0) ? PH_SKIP : PH_DELTA;
          end
        end
        PH_SKIP: begin
          brem_nxt = brem_r - 28'd1;
          if (brem_nxt == 28'd0) phase_nxt = PH_DELTA;
        end
        default: phase_nxt = PH_DELTA;
      endcase
    end
    bun.tick = 32'(tick_nxt);
    if (in_end) begin
      bun.has_err = !done_nxt;
      phase_nxt = PH_DELTA; rs_nxt = '0; cmd_nxt = '0; mtype_nxt = '0;
      tick_nxt = '0; vacc_nxt = '0; brem_nxt = '0; vseen_nxt = '0;
      held_nxt = '0; tacc_nxt = '0; done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smpte_r <= 1'b0;
      phase_r <= PH_DELTA; rs_r <= '0; cmd_r <= '0; mtype_r <= '0;
      tick_r <= '0; vacc_r <= '0; brem_r <= '0; vseen_r <= '0;
      held_r <= '0; tacc_r <= '0; done_r <= 1'b0;
    end else begin
      if (cfg_valid) smpte_r <= cfg_data;
      if (accept) begin
        phase_r <= phase_nxt; rs_r <= rs_nxt; cmd_r <= cmd_nxt; mtype_r <= mtype_nxt;
        tick_r <= tick_nxt; vacc_r <= vacc_nxt; brem_r <= brem_nxt;
        vseen_r <= vseen_nxt; held_r <= held_nxt; tacc_r <= tacc_nxt;
        done_r <= done_nxt;
      end
    end
  end

endmodule

>>> hdl/mtcp_queue.sv
// Short bundle queue between front and back end.
module mtcp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mtcp_pkg::bundle_t push_data,
  input  logic              pop,
  output mtcp_pkg::bundle_t head,
  output mtcp_pkg::qstat_t  qstat
);
  import mtcp_pkg::*;

  bundle_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head        = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{QPTR_BITS{1'b0}}, push} - {{QPTR_BITS{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> hdl/mtcp_back.sv
// Back end: walks each bundle and presents its results one beat at a time.
module mtcp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mtcp_pkg::bundle_t head,
  input  mtcp_pkg::qstat_t  qstat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              pop,
  output logic [3:0]        kind,
  output logic              last,
  output logic [mtcp_pkg::OUT_DATA_BITS-1:0] data
);
  import mtcp_pkg::*;

  logic [1:0] pos_r, pos_nxt, cur;
  logic [2:0] pres, mask, rest;
  logic [3:0] ch;
  logic [6:0] d1, d2;
  logic [23:0] tv;
  logic [28:0] sl;
  logic [7:0] sd;

  assign out_valid = !qstat.empty;
  assign pres = {head.has_err, head.has_f0, head.has_main};

  always_comb begin
    unique case (pos_r)
      2'd0:    mask = pres;
      2'd1:    mask = pres & 3'b110;
      default: mask = pres & 3'b100;
    endcase
    priority if (mask[0]) cur = 2'd0;
    else if (mask[1])     cur = 2'd1;
    else                  cur = 2'd2;
    rest = mask & ~(3'b001 << cur);
    last = (rest == 3'b000);
    pop  = out_valid && out_ready && last;
    pos_nxt = pos_r;
    if (out_valid && out_ready) pos_nxt = last ? 2'd0 : cur + 2'd1;
    kind = K_ERROR; ch = '0; d1 = '0; d2 = '0; tv = '0; sl = '0; sd = '0;
    unique case (cur)
      2'd0: begin
        kind = head.kind; ch = head.channel; d1 = head.first_data;
        d2 = head.second_data; tv = head.tempo_value; sl = head.syx_len;
        sd = head.sysex_data;
      end
      2'd1: begin
        kind = K_SYSBYTE; sd = ST_SYSEX;
      end
      default: kind = K_ERROR;
    endcase
    data = {1'b0, sd, sl, tv, d2, d1, ch, head.tick};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pos_r <= 2'd0;
    else        pos_r <= pos_nxt;
  end

endmodule

>>> hdl/midi_track_chunk_parser_top.sv
// Top level of the MIDI track chunk parser.
//
// Usage:
//  - in_*: one track-chunk byte per beat; in_tdata[7:0] is the byte and
//    in_tlast marks the last byte of the chunk.
//  - cfg_*: one-bit smpte_timing register; write only while the block is idle.
//  - out_*: result beats; out_tuser is the result kind, out_tlast marks the
//    last result of one input byte, out_tdata carries the other fields.
// Timing:
//  - The front end takes one byte per cycle while the four-entry queue has
//    room; a byte that yields results is written into the queue registers.
//  - The back end sends one result per cycle while out_tready is high, so a
//    byte with n results gives n output beats (at most three: a sysex header,
//    the F0 byte and a truncation error). Bytes with no result are not queued.
//    The front end can take new bytes while earlier results wait in the queue.
// Reset (rst_n low, synchronous) clears the parser, the queue and
// smpte_timing. When the receiver stalls the queue fills and in_tready
// falls; nothing is dropped and the output beat holds.
module midi_track_chunk_parser_top #(
  parameter int TICK_BITS = mtcp_pkg::TICK_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,    // smpte_timing
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] track_byte
  input  logic         in_tlast,    // chunk_end
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] tick, [35:32] channel, [42:36] first_data, [49:43] second_data,
  // [73:50] tempo_value, [102:74] syx_len, [110:103] sysex_data, [111] 0
  output logic [mtcp_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic [3:0]   out_tuser,   // kind
  output logic         out_tlast    // last_of_run
);
  import mtcp_pkg::*;

  bundle_t push_data, head;
  qstat_t  qstat;
  logic    push, pop;

  assign cfg_ready = 1'b1;

  mtcp_front #(.TICK_BITS(TICK_BITS)) u_front (
    .clk, .rst_n,
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data,
    .in_valid  (in_tvalid),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .qstat,
    .in_ready  (in_tready),
    .push,
    .push_data
  );

  mtcp_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .head, .qstat
  );

  mtcp_back u_back (
    .clk, .rst_n, .head, .qstat,
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .pop,
    .kind      (out_tuser),
    .last      (out_tlast),
    .data      (out_tdata)
  );

endmodule

>>> hdl/mtcp_checker.sv
// Port-level checks for the parser top, bound to it.
`include "assert_macros.svh"
module mtcp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [mtcp_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic [3:0]   out_tuser,
  input logic         out_tlast
);
  import mtcp_pkg::*;

  `MTCP_ASSERT(a_hold_valid, out_tvalid && !out_tready |=> out_tvalid)
  `MTCP_ASSERT(a_hold_data, out_tvalid && !out_tready |=> $stable(out_tdata))
  `MTCP_ASSERT(a_err_last, out_tvalid && out_tuser == K_ERROR |-> out_tlast)
  `MTCP_ASSERT(a_chan_zero, out_tvalid && out_tuser >= K_TEMPO |->
                            out_tdata[49:32] == 18'd0)
  `MTCP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid)

endmodule

bind midi_track_chunk_parser_top mtcp_checker u_chk (.*);
